// ===== sv/mpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsc_pkg: shared constants for the min perfect square count unit
// Default value width, result width and answer codes.
// ----------------------------------------------------------------------------
package mpsc_pkg;

	localparam int VALUE_WIDTH_DEF = 20;
	localparam int SQ_W            = 3;

	localparam logic [SQ_W-1:0] ANS_ONE   = 3'd1;
	localparam logic [SQ_W-1:0] ANS_TWO   = 3'd2;
	localparam logic [SQ_W-1:0] ANS_THREE = 3'd3;
	localparam logic [SQ_W-1:0] ANS_FOUR  = 3'd4;

	// Legendre residue modulo 8 after stripping factors of 4
	localparam logic [2:0] LEGENDRE_RES = 3'd7;

endpackage

// ===== sv/min_perfect_square_count_unit.sv =====
// ----------------------------------------------------------------------------
// min_perfect_square_count_unit: least number of squares summing to a value
// Steps per item: root extraction, classify, then as needed strip factors
// of 4 and a two-pointer search, and output. One item at a time; the
// search loop sets the rate. Result waits in an output register, so the next
// item is taken while it is still stalled. arst_n clears control state only.
// ----------------------------------------------------------------------------
module min_perfect_square_count_unit #(
	parameter int VALUE_WIDTH = mpsc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          value_valid,
	output logic                          value_stall,
	input  logic [VALUE_WIDTH-1:0]        value,
	output logic                          squares_valid,
	input  logic                          squares_stall,
	output logic [mpsc_pkg::SQ_W-1:0]     squares_needed
);
	import mpsc_pkg::*;

	localparam int RW    = (VALUE_WIDTH + 1) / 2;
	localparam int XW    = 2 * RW;
	localparam int REM_W = RW + 3;
	localparam int EW    = VALUE_WIDTH + 2;
	localparam int CW    = $clog2(RW + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_CLASS,
		ST_STRIP,
		ST_SEARCH,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [VALUE_WIDTH-1:0]   n_q;
	logic [VALUE_WIDTH-1:0]   m_q;
	logic [XW-1:0]            x_q;
	logic [RW-1:0]            root_q;
	logic [REM_W-1:0]         rem_q;
	logic [CW-1:0]            cnt_q;
	logic [RW:0]              lo_q;
	logic [RW-1:0]            hi_q;
	logic signed [EW-1:0]     e_q;
	logic [SQ_W-1:0]          ans_q;
	logic                     sq_valid_q;
	logic [SQ_W-1:0]          sq_q;

	// restoring square root, two bits of the value per cycle
	logic [REM_W-1:0]         rem_sh;
	logic [REM_W-1:0]         trial;
	logic                     ge;
	logic [REM_W-1:0]         rem_nxt;
	logic [RW-1:0]            root_nxt;

	assign rem_sh   = {rem_q[REM_W-3:0], x_q[XW-1:XW-2]};
	assign trial    = {1'b0, root_q, 2'b01};
	assign ge       = (rem_sh >= trial);
	assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
	assign root_nxt = {root_q[RW-2:0], ge};

	// two-pointer search: e = n - lo^2 - hi^2
	logic [RW:0]              hi_dec;
	logic signed [EW-1:0]     e_init;
	logic signed [EW-1:0]     e_lo;
	logic signed [EW-1:0]     e_hi;
	logic                     lo_gt_hi;
	logic                     e_pos;

	assign hi_dec   = {hi_q, 1'b0} - {{RW{1'b0}}, 1'b1};
	assign e_init   = $signed({{(EW-REM_W){1'b0}}, rem_q}) - $signed({{(EW-1){1'b0}}, 1'b1});
	assign e_lo     = e_q - $signed({{(EW-RW-2){1'b0}}, lo_q, 1'b1});
	assign e_hi     = e_q + $signed({{(EW-RW-1){1'b0}}, hi_dec});
	assign lo_gt_hi = (lo_q > {1'b0, hi_q});
	assign e_pos    = !e_q[EW-1] && (e_q != '0);

	assign value_stall    = (state_q != ST_IDLE);
	assign squares_valid  = sq_valid_q;
	assign squares_needed = sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sq_valid_q <= 1'b0;
		end else begin
			if (sq_valid_q && !squares_stall && state_q != ST_DONE) begin
				sq_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (value_valid) begin
						n_q     <= value;
						x_q     <= XW'(value);
						root_q  <= '0;
						rem_q   <= '0;
						cnt_q   <= CW'(RW);
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					x_q    <= {x_q[XW-3:0], 2'b00};
					rem_q  <= rem_nxt;
					root_q <= root_nxt;
					cnt_q  <= cnt_q - {{(CW-1){1'b0}}, 1'b1};
					if (cnt_q == {{(CW-1){1'b0}}, 1'b1}) begin
						state_q <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					if (rem_q == '0) begin
						ans_q   <= ANS_ONE;
						state_q <= ST_DONE;
					end else begin
						m_q     <= n_q;
						state_q <= ST_STRIP;
					end
				end
				ST_STRIP: begin
					if (m_q != '0 && m_q[1:0] == 2'b00) begin
						m_q <= {2'b00, m_q[VALUE_WIDTH-1:2]};
					end else if (m_q[2:0] == LEGENDRE_RES) begin
						ans_q   <= ANS_FOUR;
						state_q <= ST_DONE;
					end else begin
						lo_q    <= {{RW{1'b0}}, 1'b1};
						hi_q    <= root_q;
						e_q     <= e_init;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (lo_gt_hi) begin
						ans_q   <= ANS_THREE;
						state_q <= ST_DONE;
					end else if (e_q == '0) begin
						ans_q   <= ANS_TWO;
						state_q <= ST_DONE;
					end else if (e_pos) begin
						e_q  <= e_lo;
						lo_q <= lo_q + {{RW{1'b0}}, 1'b1};
					end else begin
						e_q  <= e_hi;
						hi_q <= hi_q - {{(RW-1){1'b0}}, 1'b1};
					end
				end
				ST_DONE: begin
					if (!sq_valid_q || !squares_stall) begin
						sq_q       <= ans_q;
						sq_valid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// answers are always one to four
	assert property (@(posedge clk) disable iff (!arst_n)
		squares_valid |-> (squares_needed == ANS_ONE || squares_needed == ANS_TWO ||
			squares_needed == ANS_THREE || squares_needed == ANS_FOUR))
		else $error("squares_needed out of range");

	// an accepted item starts the root extraction
	assert property (@(posedge clk) disable iff (!arst_n)
		(value_valid && !value_stall) |=> (state_q == ST_SQRT))
		else $error("accepted item did not start root");

	// the low pointer never wraps to zero during the search
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (lo_q != '0))
		else $error("search low pointer wrapped");

	// a loaded result is not overwritten while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(squares_valid && squares_stall) |=> (squares_valid && $stable(squares_needed)))
		else $error("stalled result changed");

endmodule
